/* rtl/core/rlbs_pkg.sv */
// Shared types, constants and register codes of the RGB LED blink sequencer.
// No dependencies; all core files but rlbs_ram refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rlbs_pkg;

  localparam int NUM_LEDS    = 4;
  localparam int PATTERN_LEN = 12;
  localparam int NUM_COLOURS = 3;
  localparam int NUM_PERIODS = 4;
  localparam int LED_AW      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CNT_W       = 32;

  localparam logic [15:0] PERIOD_RST = 16'd100;
  localparam logic [PATTERN_LEN-1:0] TOP_BIT = {1'b1, {(PATTERN_LEN-1){1'b0}}};

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WR_ONE = 2'd1;
  localparam logic [1:0] MODE_WR_ALL = 2'd2;

  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_BLUE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_LOW = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  led_index;
    logic [1:0]  colour_index;
    logic [15:0] pattern_first;
    logic [15:0] pattern_green;
    logic [15:0] pattern_blue;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_select;
    logic       red_level;
    logic       green_level;
    logic       blue_level;
  } out_item_t;

  typedef struct packed {
    logic [NUM_PERIODS-1:0][15:0] period;
    logic [3:0]                   act_low;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]       next_step_time;
    logic [PATTERN_LEN-1:0] step_bit;
  } led_state_t;

  typedef logic [NUM_COLOURS-1:0][PATTERN_LEN-1:0] pat_lanes_t;

endpackage

`default_nettype wire

/* rtl/core/rgb_led_blink_sequencer_core.sv */
// Top level of the RGB LED blink sequencer: tick counter, LED state and pattern
// memories, step pipeline and output register. Uses rlbs_pkg, rlbs_ram,
// rlbs_cfg_regs and rlbs_step_unit.
//
//   channel | ports                        | beat
//   --------+------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data  | mode, led, colour, three patterns
//   output  | out_valid, out_stall, out_data| led select and three levels
//   config  | cfg_we, cfg_idx, cfg_wdata   | one register write per cycle
//
// One beat per cycle while in_stall is low; a tick beat reads the memories into
// the update stage, whose state update is then registered in the output register.
// Pattern writes give no result and complete in the cycle they are accepted.
// LED state write-back is forwarded to a following read of the same LED.
// Reset is synchronous; the memories need no clearing, per-entry valid bits
// make unwritten entries read as zero. A stalled output holds one more tick
// in the update stage before in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_blink_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rlbs_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rlbs_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [rlbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rlbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = rlbs_pkg::LED_AW;
  localparam int NC = rlbs_pkg::NUM_COLOURS;
  localparam int PL = rlbs_pkg::PATTERN_LEN;
  localparam int SW = $bits(rlbs_pkg::led_state_t);

  rlbs_pkg::cfg_t cfg;

  logic                          accept;
  logic                          tick_acc;
  logic                          led_ok;
  logic                          s1_move;

  logic [rlbs_pkg::CNT_W-1:0]    tick_count_r;
  logic [rlbs_pkg::CNT_W-1:0]    tick_count_nxt;
  logic [AW-1:0]                 led_ptr_r;
  logic [AW-1:0]                 led_ptr_nxt;

  logic                          s1_valid_r;
  logic [rlbs_pkg::CNT_W-1:0]    s1_tick_r;
  logic [AW-1:0]                 s1_led_r;
  logic                          s1_fwd_hit_r;
  rlbs_pkg::led_state_t          s1_fwd_data_r;
  logic                          s1_st_vld_r;
  logic [NC-1:0]                 s1_pat_vld_r;

  logic [rlbs_pkg::NUM_LEDS-1:0]         st_vld_r;
  logic [rlbs_pkg::NUM_LEDS-1:0][NC-1:0] pat_vld_r;

  logic                          st_we;
  rlbs_pkg::led_state_t          st_rd;
  rlbs_pkg::led_state_t          st_cur;
  rlbs_pkg::led_state_t          st_new;
  logic [0:0][SW-1:0]            st_rd_raw;
  logic [0:0][SW-1:0]            st_wr_raw;

  logic [NC-1:0]                 pat_we;
  rlbs_pkg::pat_lanes_t          pat_wr;
  rlbs_pkg::pat_lanes_t          pat_rd;
  rlbs_pkg::pat_lanes_t          pat_cur;
  logic [2:0][15:0]              pat_in;

  logic [NC-1:0]                 levels;
  logic                          out_valid_r;
  rlbs_pkg::out_item_t           out_data_r;

  rlbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign accept   = in_valid && !in_stall;
  assign tick_acc = accept && (in_data.mode == rlbs_pkg::MODE_TICK);
  assign led_ok   = int'(in_data.led_index) < rlbs_pkg::NUM_LEDS;

  assign tick_count_nxt = tick_count_r + 1'b1;
  assign led_ptr_nxt    = (int'(led_ptr_r) == rlbs_pkg::NUM_LEDS - 1) ? '0 : led_ptr_r + 1'b1;

  // pattern writes: invert for active-low LEDs, keep the low PATTERN_LEN bits
  assign pat_in[0] = in_data.pattern_first;
  assign pat_in[1] = in_data.pattern_green;
  assign pat_in[2] = in_data.pattern_blue;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      pat_wr[c] = in_data.pattern_first[PL-1:0];
      if (in_data.mode == rlbs_pkg::MODE_WR_ALL) begin
        pat_wr[c] = pat_in[c][PL-1:0];
      end
      if (cfg.act_low[in_data.led_index]) begin
        pat_wr[c] = ~pat_wr[c];
      end
    end
    pat_we = '0;
    if (accept && led_ok) begin
      case (in_data.mode)
        rlbs_pkg::MODE_WR_ONE: begin
          case (in_data.colour_index)
            rlbs_pkg::COL_RED:   pat_we[0] = 1'b1;
            rlbs_pkg::COL_GREEN: pat_we[1] = 1'b1;
            rlbs_pkg::COL_BLUE:  pat_we[2] = 1'b1;
            default:             pat_we    = '0;
          endcase
        end
        rlbs_pkg::MODE_WR_ALL: pat_we = '1;
        default:               pat_we = '0;
      endcase
    end
  end

  rlbs_ram #(
    .ADDR_W (AW),
    .LANE_W (PL),
    .LANES  (NC)
  ) u_pat_ram (
    .clk     (clk),
    .wr_en   (pat_we),
    .wr_addr (in_data.led_index[AW-1:0]),
    .wr_data (pat_wr),
    .rd_en   (tick_acc),
    .rd_addr (led_ptr_nxt),
    .rd_data (pat_rd)
  );

  assign st_we        = s1_valid_r && s1_move;
  assign st_wr_raw[0] = st_new;
  assign st_rd        = st_rd_raw[0];

  rlbs_ram #(
    .ADDR_W (AW),
    .LANE_W (SW),
    .LANES  (1)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (s1_led_r),
    .wr_data (st_wr_raw),
    .rd_en   (tick_acc),
    .rd_addr (led_ptr_nxt),
    .rd_data (st_rd_raw)
  );

  always_comb begin
    if (s1_fwd_hit_r) begin
      st_cur = s1_fwd_data_r;
    end else if (s1_st_vld_r) begin
      st_cur = st_rd;
    end else begin
      st_cur = '0;
    end
    for (int c = 0; c < NC; c++) begin
      pat_cur[c] = s1_pat_vld_r[c] ? pat_rd[c] : '0;
    end
  end

  rlbs_step_unit u_step (
    .tick      (s1_tick_r),
    .cur_state (st_cur),
    .period    (cfg.period[s1_led_r]),
    .patterns  (pat_cur),
    .new_state (st_new),
    .levels    (levels)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      led_ptr_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_vld_r     <= '0;
      pat_vld_r    <= '0;
    end else begin
      if (tick_acc) begin
        tick_count_r <= tick_count_nxt;
        led_ptr_r    <= led_ptr_nxt;
      end
      if (s1_move || !s1_valid_r) begin
        s1_valid_r <= tick_acc;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
      if (st_we) begin
        st_vld_r[s1_led_r] <= 1'b1;
      end
      for (int c = 0; c < NC; c++) begin
        if (pat_we[c]) begin
          pat_vld_r[in_data.led_index[AW-1:0]][c] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_tick_r     <= tick_count_nxt;
      s1_led_r      <= led_ptr_nxt;
      s1_fwd_hit_r  <= st_we && (s1_led_r == led_ptr_nxt);
      s1_fwd_data_r <= st_new;
      s1_st_vld_r   <= st_vld_r[led_ptr_nxt];
      s1_pat_vld_r  <= pat_vld_r[led_ptr_nxt];
    end
    if (st_we) begin
      out_data_r.led_select  <= 4'(4'd1 << s1_led_r);
      out_data_r.red_level   <= levels[0];
      out_data_r.green_level <= levels[1];
      out_data_r.blue_level  <= levels[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_tick_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> s1_valid_r)
    else $error("accepted tick did not enter the update stage");

  a_write_skips_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.mode != rlbs_pkg::MODE_TICK) && !s1_valid_r) |=> !s1_valid_r)
    else $error("pattern write entered the update stage");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_data_r.led_select))
    else $error("led select is not one-hot");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(led_ptr_r) < rlbs_pkg::NUM_LEDS)
    else $error("led pointer out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/rlbs_ram.sv */
// Generic single-write, single-read synchronous RAM with per-lane write enables.
// Read data is registered; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_ram #(
  parameter int ADDR_W = 2,
  parameter int LANE_W = 8,
  parameter int LANES  = 1
) (
  input  wire logic                          clk,
  input  wire logic [LANES-1:0]              wr_en,
  input  wire logic [ADDR_W-1:0]             wr_addr,
  input  wire logic [LANES-1:0][LANE_W-1:0]  wr_data,
  input  wire logic                          rd_en,
  input  wire logic [ADDR_W-1:0]             rd_addr,
  output logic      [LANES-1:0][LANE_W-1:0]  rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [LANES-1:0][LANE_W-1:0] mem_r [DEPTH];
  logic [LANES-1:0][LANE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (wr_en[i]) begin
        mem_r[wr_addr][i] <= wr_data[i];
      end
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/rlbs_cfg_regs.sv */
// Configuration registers: step periods per LED and the active-low mask.
// Depends on rlbs_pkg for register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rlbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rlbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rlbs_pkg::cfg_t                       cfg
);

  rlbs_pkg::cfg_t cfg_r;
  rlbs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx) inside
        rlbs_pkg::REG_PERIOD0, rlbs_pkg::REG_PERIOD1,
        rlbs_pkg::REG_PERIOD2, rlbs_pkg::REG_PERIOD3: begin
          cfg_nxt.period[cfg_idx[1:0]] = cfg_wdata[15:0];
        end
        rlbs_pkg::REG_ACT_LOW: begin
          cfg_nxt.act_low = cfg_wdata[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rlbs_pkg::NUM_PERIODS; i++) begin
        cfg_r.period[i] <= rlbs_pkg::PERIOD_RST;
      end
      cfg_r.act_low <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/rlbs_step_unit.sv */
// Step update of one LED: compare counter to step time, rotate the step bit,
// advance the step time and pick the colour levels. Depends on rlbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_step_unit (
  input  wire logic [rlbs_pkg::CNT_W-1:0] tick,
  input  wire rlbs_pkg::led_state_t       cur_state,
  input  wire logic [15:0]                period,
  input  wire rlbs_pkg::pat_lanes_t       patterns,
  output rlbs_pkg::led_state_t            new_state,
  output logic [rlbs_pkg::NUM_COLOURS-1:0] levels
);

  logic [rlbs_pkg::PATTERN_LEN-1:0] shifted;
  logic                             due;

  always_comb begin
    due      = tick > cur_state.next_step_time;
    shifted  = cur_state.step_bit >> 1;
    new_state = cur_state;
    if (due) begin
      new_state.next_step_time = cur_state.next_step_time + rlbs_pkg::CNT_W'(period);
      new_state.step_bit       = (shifted == '0) ? rlbs_pkg::TOP_BIT : shifted;
    end
    for (int c = 0; c < rlbs_pkg::NUM_COLOURS; c++) begin
      levels[c] = |(patterns[c] & new_state.step_bit);
    end
  end

endmodule

`default_nettype wire
